// ===== rtl/core/response_pattern_classifier_assert.svh =====
// Assertion macros shared by the classifier design files.
// Every macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef RESPONSE_PATTERN_CLASSIFIER_ASSERT_SVH
`define RESPONSE_PATTERN_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rpc_pkg.sv =====
package rpc_pkg;

  localparam int PATTERN_W    = 64;
  localparam int NUM_PAT_REGS = 4;
  localparam int TALLY_W      = 32;
  localparam int CFG_ADDR_W   = 6;
  localparam int CFG_DATA_W   = 64;
  localparam int M_TDATA_W    = 136;

  // Register indexes. The byte address is eight times the index.
  localparam logic [2:0] REG_SUCCESS_A    = 3'd0;
  localparam logic [2:0] REG_SUCCESS_B    = 3'd1;
  localparam logic [2:0] REG_FAILURE_A    = 3'd2;
  localparam logic [2:0] REG_FAILURE_B    = 3'd3;
  localparam logic [2:0] REG_SUCCESS_USED = 3'd4;
  localparam logic [2:0] REG_FAILURE_USED = 3'd5;

  localparam logic [PATTERN_W-1:0] SUCCESS_A_RESET = 64'h0000_0000_0000_2023;
  localparam logic [1:0]           SLOTS_USED_RESET = 2'd1;

  typedef enum logic [1:0] {
    OUTCOME_SUCCESS = 2'd0,
    OUTCOME_FAILURE = 2'd1,
    OUTCOME_SILENT  = 2'd2
  } outcome_t;

  // Pattern slots in order: success a, success b, failure a, failure b.
  typedef struct packed {
    logic [NUM_PAT_REGS-1:0][PATTERN_W-1:0] pattern;
    logic [1:0]                             success_used;
    logic [1:0]                             failure_used;
  } cfg_t;

  // Packed with outcome in the lowest bits.
  typedef struct packed {
    logic [TALLY_W-1:0] silent_tally;
    logic [TALLY_W-1:0] failure_tally;
    logic [TALLY_W-1:0] success_tally;
    logic [TALLY_W-1:0] total_tally;
    logic               pattern_slot;
    outcome_t           outcome;
  } result_t;

endpackage

// ===== rtl/core/response_pattern_classifier.sv =====
// Response pattern classifier. Response bytes enter on the s_ stream, one transaction per
// byte, with s_tlast on the final byte of each response. Every byte is checked against up to
// two success and two failure patterns (each up to PATTERN_BYTES bytes, low byte first, a
// zero byte ends the pattern, an all-zero register always matches) ending at that byte. The
// last byte produces one result transaction on the m_ stream: success if an enabled success
// pattern matched, else failure if an enabled failure pattern matched or the response began
// with a nonzero byte, else no response, together with the deciding slot and four wrapping
// 32-bit tallies. The block takes one byte per clock: all pattern comparisons for a byte are
// combinational and done in parallel, and results queue in a two-entry output buffer, so the
// input stalls only while two results are waiting to be taken. A result appears on m_tvalid
// in the cycle after its last byte is accepted, unless an earlier result is held there and
// not taken in that cycle; then it waits in the second buffer entry until the earlier one is
// taken. Pattern and slot-count registers are 64-bit APB registers at byte offset 8 times
// their index and should be written while the stream is idle.
module response_pattern_classifier #(
  parameter int PATTERN_BYTES = 8,
  parameter int SUCCESS_SLOTS = 2,
  parameter int FAILURE_SLOTS = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rpc_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [rpc_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [rpc_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready,
  // Response byte stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,  // [7:0] response_byte
  input  logic                                 s_tlast,  // last_byte
  // Classification result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [1:0] outcome, [2] pattern_slot, [34:3] total_tally, [66:35] success_tally,
  // [98:67] failure_tally, [130:99] silent_tally, [135:131] zero
  output logic [rpc_pkg::M_TDATA_W-1:0]        m_tdata
);
  import rpc_pkg::*;

  localparam int RESULT_W = $bits(result_t);

  cfg_t       cfg;
  logic       cfg_write;
  logic [2:0] reg_index;
  logic       accept;
  logic       push;
  result_t    result;
  result_t    out_data;

  // Configuration registers. The index is the 8-byte word address; unused indexes are
  // ignored on write and read back as zero.
  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1:3];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern[0]   <= SUCCESS_A_RESET;
      cfg.pattern[1]   <= '0;
      cfg.pattern[2]   <= '0;
      cfg.pattern[3]   <= '0;
      cfg.success_used <= SLOTS_USED_RESET;
      cfg.failure_used <= SLOTS_USED_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        REG_SUCCESS_A:    cfg.pattern[0]   <= pwdata;
        REG_SUCCESS_B:    cfg.pattern[1]   <= pwdata;
        REG_FAILURE_A:    cfg.pattern[2]   <= pwdata;
        REG_FAILURE_B:    cfg.pattern[3]   <= pwdata;
        REG_SUCCESS_USED: cfg.success_used <= pwdata[1:0];
        REG_FAILURE_USED: cfg.failure_used <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SUCCESS_A:    prdata = cfg.pattern[0];
      REG_SUCCESS_B:    prdata = cfg.pattern[1];
      REG_FAILURE_A:    prdata = cfg.pattern[2];
      REG_FAILURE_B:    prdata = cfg.pattern[3];
      REG_SUCCESS_USED: prdata = {{(CFG_DATA_W-2){1'b0}}, cfg.success_used};
      REG_FAILURE_USED: prdata = {{(CFG_DATA_W-2){1'b0}}, cfg.failure_used};
      default:          prdata = '0;
    endcase
  end

  // The input side is held off only when both output buffer entries are occupied.
  assign accept = s_tvalid & s_tready;

  rpc_classifier #(
    .PATTERN_BYTES(PATTERN_BYTES),
    .SUCCESS_SLOTS(SUCCESS_SLOTS),
    .FAILURE_SLOTS(FAILURE_SLOTS)
  ) u_classifier (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .response_byte(s_tdata),
    .last_byte    (s_tlast),
    .cfg          (cfg),
    .push         (push),
    .result       (result)
  );

  rpc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_data  (result),
    .ready    (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_data)
  );

  assign m_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, out_data};

endmodule

// ===== rtl/core/rpc_matcher.sv =====
module rpc_matcher #(
  parameter int PATTERN_BYTES = 8
) (
  input  logic [rpc_pkg::PATTERN_W-1:0] pattern,
  input  logic [8*PATTERN_BYTES-1:0]    hist,
  output logic                          hit
);
  import rpc_pkg::*;

  // Compare the pattern against the history for every possible length in parallel,
  // then keep the comparison whose length matches the pattern's zero terminator.
  always_comb begin
    logic [PATTERN_BYTES:0] prefix_nz;
    logic [PATTERN_BYTES:0] is_len;
    logic [PATTERN_BYTES:0] eq;
    prefix_nz[0] = 1'b1;
    eq[0]        = 1'b1;
    for (int l = 1; l <= PATTERN_BYTES; l++) begin
      prefix_nz[l] = prefix_nz[l-1] & (pattern[8*(l-1) +: 8] != 8'd0);
    end
    for (int l = 0; l < PATTERN_BYTES; l++) begin
      is_len[l] = prefix_nz[l] & (pattern[8*l +: 8] == 8'd0);
    end
    is_len[PATTERN_BYTES] = prefix_nz[PATTERN_BYTES];
    for (int l = 1; l <= PATTERN_BYTES; l++) begin
      eq[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        eq[l] = eq[l] & (pattern[8*k +: 8] == hist[8*(l-1-k) +: 8]);
      end
    end
    hit = |(is_len & eq);
  end

endmodule

// ===== rtl/core/rpc_classifier.sv =====
module rpc_classifier #(
  parameter int PATTERN_BYTES = 8,
  parameter int SUCCESS_SLOTS = 2,
  parameter int FAILURE_SLOTS = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       response_byte,
  input  logic             last_byte,
  input  rpc_pkg::cfg_t    cfg,
  output logic             push,
  output rpc_pkg::result_t result
);
  import rpc_pkg::*;
  `include "response_pattern_classifier_assert.svh"

  localparam int WIN_BYTES = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
  localparam int HIST_W    = 8 * PATTERN_BYTES;

  logic [8*WIN_BYTES-1:0]   window;
  logic [8*WIN_BYTES+7:0]   hist_full;
  logic [NUM_PAT_REGS-1:0]  match_seen;
  logic [NUM_PAT_REGS-1:0]  match_now;
  logic [NUM_PAT_REGS-1:0]  hit;
  logic [NUM_PAT_REGS-1:0]  slot_en;
  logic                     at_first;
  logic                     nonempty;
  logic                     nonempty_now;
  logic [TALLY_W-1:0]       total_count;
  logic [TALLY_W-1:0]       pass_count;
  logic [TALLY_W-1:0]       fail_count;
  logic [TALLY_W-1:0]       silent_count;

  // Newest byte in the lowest bits.
  assign hist_full = {window, response_byte};

  assign slot_en[0] = cfg.success_used != 2'd0;
  assign slot_en[1] = (cfg.success_used >= 2'd2) && (SUCCESS_SLOTS >= 2);
  assign slot_en[2] = cfg.failure_used != 2'd0;
  assign slot_en[3] = (cfg.failure_used >= 2'd2) && (FAILURE_SLOTS >= 2);

  for (genvar g = 0; g < NUM_PAT_REGS; g++) begin : g_match
    rpc_matcher #(
      .PATTERN_BYTES(PATTERN_BYTES)
    ) u_matcher (
      .pattern(cfg.pattern[g]),
      .hist   (hist_full[HIST_W-1:0]),
      .hit    (hit[g])
    );
  end

  assign match_now    = match_seen | (hit & slot_en);
  assign nonempty_now = at_first ? (response_byte != 8'd0) : nonempty;
  assign push         = accept & last_byte;

  always_comb begin
    result.outcome       = OUTCOME_SILENT;
    result.pattern_slot  = 1'b0;
    result.total_tally   = total_count + 1'b1;
    result.success_tally = pass_count;
    result.failure_tally = fail_count;
    result.silent_tally  = silent_count;
    if (|match_now[1:0]) begin
      result.outcome       = OUTCOME_SUCCESS;
      result.pattern_slot  = ~match_now[0];
      result.success_tally = pass_count + 1'b1;
    end else if (|match_now[3:2]) begin
      result.outcome       = OUTCOME_FAILURE;
      result.pattern_slot  = ~match_now[2];
      result.failure_tally = fail_count + 1'b1;
    end else if (nonempty_now) begin
      result.outcome       = OUTCOME_FAILURE;
      result.failure_tally = fail_count + 1'b1;
    end else begin
      result.silent_tally  = silent_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      match_seen <= '0;
      at_first   <= 1'b1;
      nonempty   <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        window     <= '0;
        match_seen <= '0;
        at_first   <= 1'b1;
        nonempty   <= 1'b0;
      end else begin
        window     <= hist_full[8*WIN_BYTES-1:0];
        match_seen <= match_now;
        at_first   <= 1'b0;
        nonempty   <= nonempty_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count  <= '0;
      pass_count   <= '0;
      fail_count   <= '0;
      silent_count <= '0;
    end else if (push) begin
      total_count  <= result.total_tally;
      pass_count   <= result.success_tally;
      fail_count   <= result.failure_tally;
      silent_count <= result.silent_tally;
    end
  end

  `RPC_ASSERT_SAME(a_tally_sum, 1'b1,
    total_count == TALLY_W'(pass_count + fail_count + silent_count),
    "outcome tallies do not add up to the total")
  `RPC_ASSERT_NEXT(a_end_clears, push,
    at_first && (match_seen == '0) && (window == '0) && !nonempty,
    "response state not cleared after the last byte")
  `RPC_ASSERT_NEXT(a_not_first, accept && !last_byte, !at_first,
    "first-byte flag still set after a byte inside a response")

endmodule

// ===== rtl/core/rpc_out_buf.sv =====
module rpc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rpc_pkg::result_t in_data,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rpc_pkg::result_t out_data
);
  import rpc_pkg::*;
  `include "response_pattern_classifier_assert.svh"

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop   = out_valid & out_ready;
  assign ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (push && !out_valid) begin
      out_data <= in_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= in_data;
    end
  end

  `RPC_ASSERT_SAME(a_skid_implies_out, skid_valid, out_valid,
    "skid entry held while the output register is empty")
  `RPC_ASSERT_NEXT(a_skid_fill, push && out_valid && !pop, skid_valid,
    "result pushed into a full output register was dropped")
  `RPC_ASSERT_NEXT(a_skid_drain, pop && skid_valid,
    out_valid && (out_data == $past(skid_data)),
    "skid entry not moved into the output register")

endmodule
